/* src/clipped_line_rasterizer_macros.svh */
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_macros.svh
// Assertion macros used by the rasterizer checker.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_RASTERIZER_MACROS_SVH
`define CLIPPED_LINE_RASTERIZER_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define CLR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("clipped_line_rasterizer: assertion failed");

// Check that cons holds in the cycle after ante
`define CLR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("clipped_line_rasterizer: assertion failed");

`endif

/* src/clr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_pkg
// Shared types and constants of the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

  // Item opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } clr_opcode_t;

  localparam int COLOR_BITS     = 32;
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_ENABLE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_LEFT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_TOP    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_BOTTOM = 3'd4;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } clr_q_status_t;

endpackage

/* src/clipped_line_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// Bresenham line rasterizer with an optional clip window.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall is low and returns exactly one
// result per item. A load item latches a line; each step item on an active
// line reports the current pixel (written only inside the clip window when
// clipping is on) and advances it. Items pass through the two-entry command
// queue behind the setup front end, then the output register of the step
// unit. The step unit retires one item per clock while out_stall is low, as
// the error update and coordinate advance are combinational. Configuration
// writes are always ready and are meant to be made while the block is idle.
module clipped_line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [clr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic signed [COORD_BITS-1:0]         start_x,
  input  logic signed [COORD_BITS-1:0]         start_y,
  input  logic signed [COORD_BITS-1:0]         end_x,
  input  logic signed [COORD_BITS-1:0]         end_y,
  input  logic [clr_pkg::COLOR_BITS-1:0]       line_color,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 pixel_write,
  output logic signed [COORD_BITS-1:0]         pixel_x,
  output logic signed [COORD_BITS-1:0]         pixel_y,
  output logic [clr_pkg::COLOR_BITS-1:0]       pixel_color,
  output logic                                 line_done
);
  import clr_pkg::*;

  localparam int ENTRY_BITS = 6 * COORD_BITS + 2 + (COORD_BITS + 2) + 2 + COLOR_BITS;

  clr_q_status_t         q_status;
  logic                  q_push, q_pop;
  logic [ENTRY_BITS-1:0] q_in, q_out;

  assign cfg_ready = 1'b1;

  // Setup and classification
  clr_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .line_color (line_color),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  // Command queue
  clr_queue #(
    .WIDTH (ENTRY_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_status)
  );

  // Step unit and result register
  clr_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_status    (q_status),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_write (pixel_write),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .line_done   (line_done)
  );

endmodule

/* src/clr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_front
// Accepts items, classifies them and computes the line setup for loads.
// ----------------------------------------------------------------------------
module clr_front #(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_BITS = 6 * COORD_BITS + 2 + (COORD_BITS + 2) + 2 + 32
) (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         opcode,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [clr_pkg::COLOR_BITS-1:0] line_color,
  input  clr_pkg::clr_q_status_t       q_status,
  output logic                         q_push,
  output logic [ENTRY_BITS-1:0]        q_data
);
  import clr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  logic [CW:0]   diff_x, diff_y, neg_x, neg_y;
  logic          x_gt, y_gt;
  logic [CW-1:0] delta_x, delta_y;
  logic [EW-1:0] err_init;
  logic          zero_len;
  clr_opcode_t   op;

  // Stall while the queue has no room; push every accepted item
  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;
  assign op       = clr_opcode_t'(opcode);

  // Absolute deltas and step directions
  always_comb begin
    diff_x  = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
    diff_y  = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
    neg_x   = -diff_x;
    neg_y   = -diff_y;
    x_gt    = end_x > start_x;
    y_gt    = end_y > start_y;
    delta_x = x_gt ? diff_x[CW-1:0] : neg_x[CW-1:0];
    delta_y = y_gt ? diff_y[CW-1:0] : neg_y[CW-1:0];
  end

  // Initial error: half the major delta, or minus half of dy
  always_comb begin
    if (delta_x > delta_y) begin
      err_init = {2'b00, delta_x} >> 1;
    end else begin
      err_init = -({2'b00, delta_y} >> 1);
    end
  end

  assign zero_len = (start_x == end_x) && (start_y == end_y);

  // Pack the command for the back end
  assign q_data = {op, zero_len, start_x, start_y, end_x, end_y,
                   delta_x, delta_y, !x_gt, !y_gt, err_init, line_color};

endmodule

/* src/clr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module clr_queue #(
  parameter int WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output logic [WIDTH-1:0]       pop_data,
  output clr_pkg::clr_q_status_t status
);
  import clr_pkg::*;

  logic [WIDTH-1:0]     entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign status.full  = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = entries[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/clr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_back
// Holds the line state and clip window, steps the line and drives results.
// ----------------------------------------------------------------------------
module clr_back #(
  parameter int COORD_BITS = 12,
  parameter int ENTRY_BITS = 6 * COORD_BITS + 2 + (COORD_BITS + 2) + 2 + 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [clr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]                cfg_data,
  input  clr_pkg::clr_q_status_t               q_status,
  input  logic [ENTRY_BITS-1:0]                q_data,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 pixel_write,
  output logic signed [COORD_BITS-1:0]         pixel_x,
  output logic signed [COORD_BITS-1:0]         pixel_y,
  output logic [clr_pkg::COLOR_BITS-1:0]       pixel_color,
  output logic                                 line_done
);
  import clr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0]        STEP_POS  = CW'(1);
  localparam logic [CW-1:0]        STEP_NEG  = {CW{1'b1}};

  // Unpacked command
  clr_opcode_t          c_op;
  logic                 c_zero;
  logic signed [CW-1:0] c_sx, c_sy, c_ex, c_ey;
  logic [CW-1:0]        c_dx, c_dy;
  logic                 c_dxn, c_dyn;
  logic [EW-1:0]        c_err;
  logic [COLOR_BITS-1:0] c_color;

  // Line state
  logic signed [CW-1:0] cur_x, cur_y, dest_x, dest_y;
  logic [CW-1:0]        delta_x, delta_y;
  logic                 dir_x_neg, dir_y_neg;
  logic signed [EW-1:0] error_term;
  logic [COLOR_BITS-1:0] held_color;
  logic                 active;

  // Clip window
  logic                 clip_enable;
  logic signed [CW-1:0] clip_left, clip_right, clip_top, clip_bottom;

  // Step logic
  logic signed [EW-1:0] dxs, dys, err_next;
  logic                 adv_x, adv_y, in_window;
  logic signed [CW-1:0] cur_x_next, cur_y_next;
  logic                 active_next, out_free;

  assign {c_op, c_zero, c_sx, c_sy, c_ex, c_ey,
          c_dx, c_dy, c_dxn, c_dyn, c_err, c_color} = q_data;

  // Take a command whenever the output register is free
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = !q_status.empty && out_free;

  // Bresenham step from the current point
  always_comb begin
    dxs         = $signed({2'b00, delta_x});
    dys         = $signed({2'b00, delta_y});
    adv_x       = (error_term > -dxs) && (cur_x != dest_x);
    adv_y       = (error_term < dys) && (cur_y != dest_y);
    err_next    = error_term - (adv_x ? dys : '0) + (adv_y ? dxs : '0);
    cur_x_next  = adv_x ? cur_x + (dir_x_neg ? STEP_NEG : STEP_POS) : cur_x;
    cur_y_next  = adv_y ? cur_y + (dir_y_neg ? STEP_NEG : STEP_POS) : cur_y;
    active_next = !((cur_x_next == dest_x) && (cur_y_next == dest_y));
    in_window   = !clip_enable ||
                  ((cur_x > clip_left) && (cur_x < clip_right) &&
                   (cur_y > clip_top) && (cur_y < clip_bottom));
  end

  // Control state: clip window, active flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b0;
      clip_left   <= COORD_MIN;
      clip_right  <= COORD_MAX;
      clip_top    <= COORD_MIN;
      clip_bottom <= COORD_MAX;
      active      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CLIP_ENABLE: clip_enable <= cfg_data[0];
          CFG_CLIP_LEFT:   clip_left   <= $signed(cfg_data);
          CFG_CLIP_RIGHT:  clip_right  <= $signed(cfg_data);
          CFG_CLIP_TOP:    clip_top    <= $signed(cfg_data);
          CFG_CLIP_BOTTOM: clip_bottom <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (q_pop) begin
        unique case (c_op)
          OP_LOAD: active <= !c_zero;
          OP_STEP: if (active) begin
            active <= active_next;
          end
          default: ;
        endcase
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Line registers and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      unique case (c_op)
        OP_LOAD: begin
          cur_x       <= c_sx;
          cur_y       <= c_sy;
          dest_x      <= c_ex;
          dest_y      <= c_ey;
          delta_x     <= c_dx;
          delta_y     <= c_dy;
          dir_x_neg   <= c_dxn;
          dir_y_neg   <= c_dyn;
          error_term  <= $signed(c_err);
          held_color  <= c_color;
          pixel_write <= 1'b0;
          pixel_x     <= '0;
          pixel_y     <= '0;
          pixel_color <= '0;
          line_done   <= c_zero;
        end
        OP_STEP: begin
          if (active) begin
            cur_x       <= cur_x_next;
            cur_y       <= cur_y_next;
            error_term  <= err_next;
            pixel_write <= in_window;
            pixel_x     <= cur_x;
            pixel_y     <= cur_y;
            pixel_color <= held_color;
            line_done   <= !active_next;
          end else begin
            pixel_write <= 1'b0;
            pixel_x     <= '0;
            pixel_y     <= '0;
            pixel_color <= '0;
            line_done   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* src/clr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clr_checker
// Port-level checks on the clipped line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "clipped_line_rasterizer_macros.svh"

module clr_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic                               pixel_write,
  input logic signed [COORD_BITS-1:0]       pixel_x,
  input logic signed [COORD_BITS-1:0]       pixel_y,
  input logic [clr_pkg::COLOR_BITS-1:0]     pixel_color,
  input logic                               line_done
);

  // Hold a stalled item
  `CLR_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_write) && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color) && $stable(line_done))

  // No result right after reset
  `CLR_ASSERT_IMP(a_reset_idle, clk, rst, $past(rst), !out_valid)

  // Drain the queue and output register once inputs stop and the output is free
  `CLR_ASSERT_IMP(a_drain, clk, rst, !$past(in_valid) && !$past(in_valid, 2) && !$past(in_valid, 3) && !$past(out_stall) && !$past(out_stall, 2) && !$past(out_stall, 3), !out_valid)

endmodule

bind clipped_line_rasterizer clr_checker #(.COORD_BITS(COORD_BITS)) u_clr_checker (.*);
